// ----- rtl/mpwd_pkg.sv -----
// Shared types and constants for the multi-port window debounce block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mpwd_pkg;

  localparam int PORT_W     = 8;
  localparam int NUM_PORTS  = 4;
  localparam int SAMPLE_W   = PORT_W * NUM_PORTS;
  localparam int WINDOW_DEF = 5;

  localparam logic [SAMPLE_W-1:0] BYPASS_RESET = 32'h0000_000F;

  // Running reduction handed from cell to cell along the sample chain
  typedef struct packed {
    logic [SAMPLE_W-1:0] all_and;
    logic [SAMPLE_W-1:0] any_or;
  } mpwd_red_t;

endpackage

// ----- rtl/mpwd_cell.sv -----
// One stage of the sample history chain: holds one past sample, shifts it on
// to the next cell on each request, and folds it into the running AND/OR.
// Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_cell
  import mpwd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  mpwd_red_t           red_in,
  output logic [SAMPLE_W-1:0] sample_out,
  output mpwd_red_t           red_out
);

  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] sample_nxt;

  assign sample_nxt = shift_en ? sample_in : sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  assign sample_out      = sample_r;
  assign red_out.all_and = red_in.all_and & sample_r;
  assign red_out.any_or  = red_in.any_or | sample_r;

endmodule

// ----- rtl/mpwd_out.sv -----
// Output stage: updates the held debounced word and drives the result
// handshake; the held register is the output register itself.
// Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_out
  import mpwd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                accept,
  input  logic [SAMPLE_W-1:0] cur,
  input  mpwd_red_t           red,
  input  logic [SAMPLE_W-1:0] bypass_mask,
  output logic [SAMPLE_W-1:0] held,
  output logic                out_valid,
  input  logic                out_stall
);

  logic [SAMPLE_W-1:0] held_r;
  logic [SAMPLE_W-1:0] held_nxt;
  logic                valid_r;
  logic                valid_nxt;
  logic [SAMPLE_W-1:0] same;

  // Hold off new requests only while a result waits and the receiver stalls
  assign in_stall = valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Adopt bits that are steady over the window or bypassed
  assign same     = red.all_and | ~red.any_or | bypass_mask;
  assign held_nxt = accept ? ((held_r & ~same) | (cur & same)) : held_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign held      = held_r;
  assign out_valid = valid_r;

endmodule

// ----- rtl/multi_port_window_debounce.sv -----
// Top level of the multi-port window debounce: sample chain, held word and
// bypass mask register. Depends on mpwd_pkg, mpwd_cell and mpwd_out.
//
// Usage:
//   Input channel (in_valid / in_stall, raw_port0..3) carries one raw sample
//   of the four 8-bit ports per request. Result channel (out_valid /
//   out_stall, stable_port0..3) returns the debounced held value of each port
//   after that sample. A bit follows the raw value once it has been equal over
//   the last WINDOW samples (the new one included), or at once when its
//   cfg_wr_data bypass bit is set; otherwise it keeps its held value.
//   The result is shown in the cycle after the request is taken. Throughput
//   is one sample per cycle unless the receiver stalls. The window is a
//   chain of WINDOW-1 cells that shift on every request; the AND/OR
//   reduction runs along the chain in the same cycle, into the held register.
//   Reset clears the sample history and held value to zero, sets the bypass
//   mask to 0x0F and empties the output. While the receiver stalls a waiting
//   result, in_stall is high and the result and history hold; otherwise a new
//   request is taken every cycle. Write cfg only while the block is idle.
`timescale 1ns / 1ps

module multi_port_window_debounce
  import mpwd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [SAMPLE_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PORT_W-1:0]  in_raw_port0,
  input  logic [PORT_W-1:0]  in_raw_port1,
  input  logic [PORT_W-1:0]  in_raw_port2,
  input  logic [PORT_W-1:0]  in_raw_port3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PORT_W-1:0]  out_stable_port0,
  output logic [PORT_W-1:0]  out_stable_port1,
  output logic [PORT_W-1:0]  out_stable_port2,
  output logic [PORT_W-1:0]  out_stable_port3
);

  logic [SAMPLE_W-1:0] bypass_r;
  logic [SAMPLE_W-1:0] bypass_nxt;
  logic [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W-1:0] held;
  logic                accept;

  logic [SAMPLE_W-1:0] sample_chain [WINDOW];
  mpwd_red_t           red_chain    [WINDOW];

  assign bypass_nxt = cfg_wr_en ? cfg_wr_data : bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= BYPASS_RESET;
    end else begin
      bypass_r <= bypass_nxt;
    end
  end

  assign cur = {in_raw_port3, in_raw_port2, in_raw_port1, in_raw_port0};

  // The new sample heads the chain and seeds the reduction
  assign sample_chain[0]      = cur;
  assign red_chain[0].all_and = cur;
  assign red_chain[0].any_or  = cur;

  for (genvar k = 0; k < WINDOW - 1; k++) begin : g_cell
    mpwd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (accept),
      .sample_in  (sample_chain[k]),
      .red_in     (red_chain[k]),
      .sample_out (sample_chain[k+1]),
      .red_out    (red_chain[k+1])
    );
  end

  mpwd_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accept      (accept),
    .cur         (cur),
    .red         (red_chain[WINDOW-1]),
    .bypass_mask (bypass_r),
    .held        (held),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  assign out_stable_port0 = held[PORT_W-1:0];
  assign out_stable_port1 = held[2*PORT_W-1:PORT_W];
  assign out_stable_port2 = held[3*PORT_W-1:2*PORT_W];
  assign out_stable_port3 = held[4*PORT_W-1:3*PORT_W];

endmodule

// ----- tb/multi_port_window_debounce_tb.sv -----
// Self-checking bench for multi_port_window_debounce: random and directed port
// samples under several bypass masks, checked against a bit-level debounce
// predictor. Depends on mpwd_pkg and the block's RTL.
`timescale 1ns / 1ps

module multi_port_window_debounce_tb;
  import mpwd_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int HOLDOFF_CYCLES = 40;
  localparam int CYCLE_LIMIT = 100000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PORT_W-1:0]   in_raw_port0 = '0;
  logic [PORT_W-1:0]   in_raw_port1 = '0;
  logic [PORT_W-1:0]   in_raw_port2 = '0;
  logic [PORT_W-1:0]   in_raw_port3 = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PORT_W-1:0]   out_stable_port0;
  logic [PORT_W-1:0]   out_stable_port1;
  logic [PORT_W-1:0]   out_stable_port2;
  logic [PORT_W-1:0]   out_stable_port3;

  // Debounce predictor and the queue of held words still owed by the block
  class debounce_tracker;
    logic [SAMPLE_W-1:0] ring [WIN];
    int unsigned         slot;
    logic [SAMPLE_W-1:0] held;
    logic [SAMPLE_W-1:0] bypass;
    logic [SAMPLE_W-1:0] expected_held [$];
    int unsigned         mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot = 0;
      held = '0;
      bypass = BYPASS_RESET;
      mismatches = 0;
    endfunction

    function void set_bypass(logic [SAMPLE_W-1:0] m);
      bypass = m;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      logic [SAMPLE_W-1:0] all_and;
      logic [SAMPLE_W-1:0] any_or;
      logic [SAMPLE_W-1:0] settled;
      ring[slot] = sample;
      slot = (slot + 1 == WIN) ? 0 : slot + 1;
      all_and = '1;
      any_or = '0;
      foreach (ring[i]) begin
        all_and &= ring[i];
        any_or |= ring[i];
      end
      // adopt bits that are steady over the window or bypassed, hold the rest
      settled = all_and | ~any_or | bypass;
      held = (held & ~settled) | (sample & settled);
      expected_held.push_back(held);
    endfunction

    function void check_held(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      bit                  bad;
      if (expected_held.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: ports %h %h %h %h",
                   got[31:24], got[23:16], got[15:8], got[7:0]);
        mismatches++;
        return;
      end
      want = expected_held.pop_front();
      bad = 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (got[p*PORT_W +: PORT_W] !== want[p*PORT_W +: PORT_W]) bad = 1'b1;
      end
      if (bad) begin
        if (mismatches < 10)
          $display("held ports mismatch: expected %h %h %h %h, got %h %h %h %h",
                   want[31:24], want[23:16], want[15:8], want[7:0],
                   got[31:24], got[23:16], got[15:8], got[7:0]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_held.size();
    endfunction
  endclass

  debounce_tracker board = new();

  bit                  calm = 1'b0;
  int unsigned         holdoff_asks = 0;
  int unsigned         holdoff_seen = 0;
  int unsigned         holdoff_left = 0;
  int unsigned         cycles = 0;
  logic [SAMPLE_W-1:0] level = '0;

  multi_port_window_debounce #(.WINDOW(WIN)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_port0     (in_raw_port0),
    .in_raw_port1     (in_raw_port1),
    .in_raw_port2     (in_raw_port2),
    .in_raw_port3     (in_raw_port3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stable_port0 (out_stable_port0),
    .out_stable_port1 (out_stable_port1),
    .out_stable_port2 (out_stable_port2),
    .out_stable_port3 (out_stable_port3)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_asks) begin
      holdoff_seen = holdoff_asks;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_held({out_stable_port3, out_stable_port2,
                        out_stable_port1, out_stable_port0});
  end

  // Offer one request, called at a falling edge; returns at a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while (!calm && ($urandom_range(99) < 18)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_raw_port3, in_raw_port2, in_raw_port1, in_raw_port0} <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(sample);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_bypass(input logic [SAMPLE_W-1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_bypass(m);
    @(negedge clk);
  endtask

  // Bouncing inputs: a slowly changing level with short glitches, plus noise
  function automatic logic [SAMPLE_W-1:0] bouncy_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 22) level ^= $urandom & $urandom;
    if (pick < 45) return level ^ (32'h1 << $urandom_range(31));
    return level;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) holdoff_asks++;
      calm = (i >= 2 * n / 3) && (i < 2 * n / 3 + 40);
      send_sample(bouncy_sample());
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset zeros in the window, rise to all ones, alternation, fall
    send_sample(32'h0000_0000);
    repeat (6) send_sample(32'hFFFF_FFFF);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
    send_sample(32'h00FF_8001);
    send_sample(32'hFF00_0180);
    repeat (6) send_sample(32'h0000_0000);
    repeat (5) send_sample(32'h80FF_017F);
    drain();

    run_random(180);
    write_bypass(32'h0000_0000);
    run_random(190);
    write_bypass(32'hFFFF_FFFF);
    run_random(80);
    write_bypass($urandom);
    run_random(150);
    write_bypass($urandom);
    run_random(150);

    repeat (5) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- multi_port_window_debounce.f -----
rtl/mpwd_pkg.sv
rtl/mpwd_cell.sv
rtl/mpwd_out.sv
rtl/multi_port_window_debounce.sv
tb/multi_port_window_debounce_tb.sv
